// File: hdl/wiss_pkg.sv
// ----------------------------------------------------------------------------
// wiss_pkg
// shared types, field widths, element ids and helper functions for the
// information element ssid and security scanner
// ----------------------------------------------------------------------------
package wiss_pkg;

    localparam int DATA_W = 8;
    localparam int CHAR_W = 7;
    localparam int IDX_W  = 6;

    localparam logic [DATA_W-1:0] ID_SSID   = 8'd0;
    localparam logic [DATA_W-1:0] ID_RSN    = 8'd48;
    localparam logic [DATA_W-1:0] ID_VENDOR = 8'd221;

    localparam logic [DATA_W-1:0] OUI_LEN  = 8'd4;
    localparam logic [DATA_W-1:0] BODY_MAX = 8'd255;
    localparam logic [DATA_W-1:0] PRINT_LO = 8'd32;
    localparam logic [DATA_W-1:0] PRINT_HI = 8'd127;
    localparam logic [CHAR_W-1:0] SUB_CHAR = 7'd63;

    typedef enum logic [3:0] {
        ST_ID   = 4'b0001,
        ST_LEN  = 4'b0010,
        ST_BODY = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    // wpa vendor prefix 00 50 f2 01
    function automatic logic [DATA_W-1:0] oui_byte(input logic [1:0] idx);
        logic [DATA_W-1:0] v;
        case (idx)
            2'd0:    v = 8'h00;
            2'd1:    v = 8'h50;
            2'd2:    v = 8'hf2;
            default: v = 8'h01;
        endcase
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] sanitize(input logic [DATA_W-1:0] b);
        logic [CHAR_W-1:0] c;
        if (b >= PRINT_LO && b < PRINT_HI) begin
            c = b[CHAR_W-1:0];
        end else begin
            c = SUB_CHAR;
        end
        return c;
    endfunction

endpackage

// File: hdl/wiss_if.sv
// ----------------------------------------------------------------------------
// wiss_if
// valid/ready channels: element buffer bytes in, ssid characters out
// ----------------------------------------------------------------------------
interface wiss_in_if;
    import wiss_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              byte_present;
    logic              is_last;

    modport source (output valid, output data_byte, output byte_present,
                    output is_last, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input is_last, output ready);
endinterface

interface wiss_out_if;
    import wiss_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ssid_char;
    logic [IDX_W-1:0]  char_index;
    logic [IDX_W-1:0]  ssid_length;
    logic              is_secured;
    logic              run_end;

    modport source (output valid, output ssid_char, output char_index,
                    output ssid_length, output is_secured, output run_end,
                    input ready);
    modport sink   (input valid, input ssid_char, input char_index,
                    input ssid_length, input is_secured, input run_end,
                    output ready);
endinterface

// File: hdl/wiss_name_ram.sv
// ----------------------------------------------------------------------------
// wiss_name_ram
// ssid name store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module wiss_name_ram #(
    parameter int DEPTH = 63,
    parameter int AW    = 6
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [wiss_pkg::CHAR_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [wiss_pkg::CHAR_W-1:0] o_rdata
);
    import wiss_pkg::*;

    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/wlan_ie_ssid_security_scan_unit.sv
// ----------------------------------------------------------------------------
// wlan_ie_ssid_security_scan_unit
// parses a beacon information element buffer and reports ssid and security
// ----------------------------------------------------------------------------
// i_in carries one buffer byte per beat (byte_present) and marks the final
// beat with is_last; a beat with byte_present low only ends the buffer.
// while parsing, one beat is taken every cycle.
// the ssid body is sanitized and written into a name memory as it arrives;
// id, length and security tracking live in registers.
// after the last beat, intake stops and o_out delivers one beat per stored
// ssid character, or one beat with ssid_length 0 for a hidden network.
// the first character passes through the memory read register and then the
// output register; a hidden result goes straight into the output register.
// characters then follow one per cycle while o_out is not stalled, and intake
// stays paused until the readout of the ssid is over.
// a stall on o_out holds the output register and the read stage; no
// character is lost or repeated.
// after the beat flagged run_end is taken, the parser is back in its reset
// state and i_in.ready rises again.
// reset (i_rst_n low, synchronous) returns to expecting an element id with
// no name and no security; the name memory is not cleared.
// ----------------------------------------------------------------------------
module wlan_ie_ssid_security_scan_unit #(
    parameter int SSID_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wiss_in_if.sink    i_in,
    wiss_out_if.source o_out
);
    import wiss_pkg::*;

    localparam int NAME_CAP = SSID_BYTES - 1;
    localparam int LW       = $clog2(SSID_BYTES);

    t_state            r_state, n_state;
    logic [DATA_W-1:0] r_elem_id, n_elem_id;
    logic [DATA_W-1:0] r_body_left, n_body_left;
    logic [DATA_W-1:0] r_body_pos, n_body_pos;
    logic              r_oui, n_oui;
    logic              r_secured, n_secured;
    logic [LW-1:0]     r_name_len, n_name_len;
    logic [LW-1:0]     r_pend, n_pend;
    logic [LW-1:0]     r_rd_idx, n_rd_idx;
    logic [LW-1:0]     r_q_idx, n_q_idx;
    logic              r_q_valid, n_q_valid;

    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_out_char, n_out_char;
    logic [IDX_W-1:0]  r_out_idx, n_out_idx;
    logic [IDX_W-1:0]  r_out_len, n_out_len;
    logic              r_out_sec, n_out_sec;
    logic              r_out_end, n_out_end;

    logic              in_fire, out_fire, fin, q_move, issue;
    logic              wr_en;
    logic [CHAR_W-1:0] wr_data;
    logic [CHAR_W-1:0] rd_data;
    logic [DATA_W-1:0] b;

    assign b        = i_in.data_byte;
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign q_move   = r_q_valid && (!r_out_valid || o_out.ready);
    assign issue    = (r_state == ST_EMIT) && (r_rd_idx < r_name_len)
                      && (!r_q_valid || q_move);
    assign wr_data  = sanitize(b);

    wiss_name_ram #(
        .DEPTH (NAME_CAP),
        .AW    (LW)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_pend),
        .i_wdata (wr_data),
        .i_re    (issue),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_data)
    );

    // parser and readout sequencing
    always_comb begin
        n_state     = r_state;
        n_elem_id   = r_elem_id;
        n_body_left = r_body_left;
        n_body_pos  = r_body_pos;
        n_oui       = r_oui;
        n_secured   = r_secured;
        n_name_len  = r_name_len;
        n_pend      = r_pend;
        n_rd_idx    = r_rd_idx;
        n_q_idx     = r_q_idx;
        n_q_valid   = r_q_valid;
        wr_en       = 1'b0;
        fin         = 1'b0;

        if (in_fire && i_in.byte_present) begin
            case (r_state)
                ST_ID: begin
                    n_elem_id = b;
                    n_state   = ST_LEN;
                end
                ST_LEN: begin
                    n_body_left = b;
                    n_body_pos  = '0;
                    n_oui       = 1'b1;
                    n_pend      = '0;
                    if (b == '0) begin
                        fin = 1'b1;
                    end else begin
                        n_state = ST_BODY;
                    end
                end
                ST_BODY: begin
                    if (r_body_pos < OUI_LEN && b != oui_byte(r_body_pos[1:0])) begin
                        n_oui = 1'b0;
                    end
                    if (r_elem_id == ID_SSID && r_name_len == '0
                        && r_pend < LW'(NAME_CAP)) begin
                        wr_en  = 1'b1;
                        n_pend = r_pend + 1'b1;
                    end
                    if (r_body_pos != BODY_MAX) begin
                        n_body_pos = r_body_pos + 1'b1;
                    end
                    n_body_left = r_body_left - 1'b1;
                    if (r_body_left == 8'd1) begin
                        fin = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (fin) begin
            n_state = ST_ID;
            if (r_elem_id == ID_SSID && r_name_len == '0) begin
                n_name_len = n_pend;
            end
            if (r_elem_id == ID_RSN) begin
                n_secured = 1'b1;
            end
            if (r_elem_id == ID_VENDOR && n_body_pos >= OUI_LEN && n_oui) begin
                n_secured = 1'b1;
            end
        end

        if (in_fire && i_in.is_last) begin
            n_state = ST_EMIT;
        end

        // read stage of the name memory
        if (issue) begin
            n_rd_idx  = r_rd_idx + 1'b1;
            n_q_idx   = r_rd_idx;
            n_q_valid = 1'b1;
        end else if (q_move) begin
            n_q_valid = 1'b0;
        end

        // final beat taken: back to reset state
        if (out_fire && r_out_end) begin
            n_state     = ST_ID;
            n_elem_id   = '0;
            n_body_left = '0;
            n_body_pos  = '0;
            n_oui       = 1'b1;
            n_secured   = 1'b0;
            n_name_len  = '0;
            n_pend      = '0;
            n_rd_idx    = '0;
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_idx   = r_out_idx;
        n_out_len   = r_out_len;
        n_out_sec   = r_out_sec;
        n_out_end   = r_out_end;

        if (out_fire) begin
            n_out_valid = 1'b0;
        end
        if (q_move) begin
            n_out_valid = 1'b1;
            n_out_char  = rd_data;
            n_out_idx   = IDX_W'(r_q_idx);
            n_out_len   = IDX_W'(r_name_len);
            n_out_sec   = r_secured;
            n_out_end   = (r_q_idx == r_name_len - 1'b1);
        end else if (r_state == ST_EMIT && r_name_len == '0 && !r_out_valid) begin
            n_out_valid = 1'b1;
            n_out_char  = '0;
            n_out_idx   = '0;
            n_out_len   = '0;
            n_out_sec   = r_secured;
            n_out_end   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ID;
            r_elem_id   <= '0;
            r_body_left <= '0;
            r_body_pos  <= '0;
            r_oui       <= 1'b1;
            r_secured   <= 1'b0;
            r_name_len  <= '0;
            r_pend      <= '0;
            r_rd_idx    <= '0;
            r_q_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_elem_id   <= n_elem_id;
            r_body_left <= n_body_left;
            r_body_pos  <= n_body_pos;
            r_oui       <= n_oui;
            r_secured   <= n_secured;
            r_name_len  <= n_name_len;
            r_pend      <= n_pend;
            r_rd_idx    <= n_rd_idx;
            r_q_valid   <= n_q_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_idx    <= n_q_idx;
        r_out_char <= n_out_char;
        r_out_idx  <= n_out_idx;
        r_out_len  <= n_out_len;
        r_out_sec  <= n_out_sec;
        r_out_end  <= n_out_end;
    end

    assign i_in.ready        = (r_state != ST_EMIT);
    assign o_out.valid       = r_out_valid;
    assign o_out.ssid_char   = r_out_char;
    assign o_out.char_index  = r_out_idx;
    assign o_out.ssid_length = r_out_len;
    assign o_out.is_secured  = r_out_sec;
    assign o_out.run_end     = r_out_end;

    a_out_only_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> r_state == ST_EMIT)
        else $error("result beat outside readout");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && r_out_end) |=> (r_state == ST_ID && r_name_len == '0
                                     && !r_q_valid && !r_out_valid))
        else $error("parser not cleared after final beat");

    a_name_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_name_len <= LW'(NAME_CAP) && r_pend <= LW'(NAME_CAP))
        else $error("name length beyond store depth");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_valid |-> (r_q_idx < r_name_len && r_state == ST_EMIT))
        else $error("name read beyond stored length");

    a_secured_stable_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && $past(r_state) == ST_EMIT && !$past(out_fire && r_out_end))
            |-> $stable(r_secured) && $stable(r_name_len))
        else $error("scan result changed during readout");

endmodule
